/* src/kst_pkg.sv */
// Shared types and constants for the key event statistics table.
package kst_pkg;

	localparam int POSITIONS = 64;
	localparam int IDX_W     = (POSITIONS > 1) ? $clog2(POSITIONS) : 1;

	localparam logic [15:0] SAT16 = 16'hFFFF;

	localparam logic [31:0] GAP_LIM_5  = 32'd5;
	localparam logic [31:0] GAP_LIM_10 = 32'd10;
	localparam logic [31:0] GAP_LIM_20 = 32'd20;
	localparam logic [31:0] GAP_LIM_50 = 32'd50;

	typedef enum logic [1:0] {
		OP_EVENT = 2'd0,
		OP_READ  = 2'd1,
		OP_CLEAR = 2'd2
	} op_t;

	typedef struct packed {
		logic [15:0]       press_cnt;
		logic [15:0]       release_cnt;
		logic [7:0]        last_src;
		logic [15:0]       min_hold;
		logic [15:0]       min_gap;
		logic [3:0][15:0]  bucket;
		logic [31:0]       press_time;
		logic [31:0]       release_time;
		logic              press_seen;
		logic              release_seen;
	} entry_t;

	localparam entry_t ENTRY_RESET = '{
		press_cnt:    16'd0,
		release_cnt:  16'd0,
		last_src:     8'd0,
		min_hold:     SAT16,
		min_gap:      SAT16,
		bucket:       '0,
		press_time:   32'd0,
		release_time: 32'd0,
		press_seen:   1'b0,
		release_seen: 1'b0
	};

	localparam int ENTRY_W = $bits(entry_t);

endpackage

/* src/kst_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module kst_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic                                      re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* src/kst_update.sv */
// Per-position statistics update for one press or release beat.
module kst_update import kst_pkg::*; (
	input  entry_t      cur,
	input  logic        pressed,
	input  logic [31:0] timestamp_ms,
	input  logic [7:0]  source,
	output entry_t      nxt
);

	logic [31:0] delta;

	function automatic logic [15:0] bump16(input logic [15:0] v);
		return (v == SAT16) ? v : v + 16'd1;
	endfunction

	always_comb begin
		nxt = cur;
		nxt.last_src = source;
		if (pressed) begin
			delta = timestamp_ms - cur.release_time;
			nxt.press_cnt = bump16(cur.press_cnt);
			if (cur.release_seen) begin
				if (delta < {16'd0, cur.min_gap}) begin
					nxt.min_gap = delta[15:0];
				end
				priority if (delta < GAP_LIM_5) begin
					nxt.bucket[0] = bump16(cur.bucket[0]);
				end else if (delta < GAP_LIM_10) begin
					nxt.bucket[1] = bump16(cur.bucket[1]);
				end else if (delta < GAP_LIM_20) begin
					nxt.bucket[2] = bump16(cur.bucket[2]);
				end else if (delta < GAP_LIM_50) begin
					nxt.bucket[3] = bump16(cur.bucket[3]);
				end
			end
			nxt.press_time = timestamp_ms;
			nxt.press_seen = 1'b1;
		end else begin
			delta = timestamp_ms - cur.press_time;
			nxt.release_cnt = bump16(cur.release_cnt);
			if (cur.press_seen && (delta < {16'd0, cur.min_hold})) begin
				nxt.min_hold = delta[15:0];
			end
			nxt.release_time = timestamp_ms;
			nxt.release_seen = 1'b1;
		end
	end

endmodule

/* src/key_event_stats_table_top.sv */
// Top level of the key event statistics table.
// Per-position statistics live in one RAM entry per key position, read through a registered
// read port. For an in-range key event the entry is read in the accept cycle and the updated
// entry is written back in the next, during which no new beat is taken. A read waits in a read
// state until the output register is empty or the consumer takes the previous result, and no
// new beat is taken meanwhile. A clear drops every per-position valid flag, and an entry whose
// flag is low reads as its reset values. Clears, out-of-range events and unused op codes leave
// the block idle, so it stays ready for the next beat.
module key_event_stats_table_top import kst_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  op,
	input  logic [7:0]  position,
	input  logic        pressed,
	input  logic [31:0] timestamp_ms,
	input  logic [7:0]  source,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        valid_res,
	output logic [15:0] press_total,
	output logic [15:0] release_total,
	output logic [7:0]  last_source_id,
	output logic [15:0] min_hold_ms,
	output logic [15:0] min_gap_ms,
	output logic [15:0] gaps_under_5,
	output logic [15:0] gaps_under_10,
	output logic [15:0] gaps_under_20,
	output logic [15:0] gaps_under_50
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MODIFY,
		ST_READ
	} state_t;

	state_t           state_q;
	logic [POSITIONS-1:0] vld_q;
	logic [IDX_W-1:0] idx_q;
	logic             in_range_q;
	logic             pressed_q;
	logic [31:0]      ts_q;
	logic [7:0]       src_q;
	logic             out_valid_q;
	logic             in_fire;
	logic             in_range;
	logic [IDX_W-1:0] in_idx;
	logic [ENTRY_W-1:0] rdata;
	entry_t           cur;
	entry_t           nxt;
	logic             wr_en;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign in_range  = {1'b0, position} < 9'(POSITIONS);
	assign in_idx    = position[IDX_W-1:0];
	assign wr_en     = (state_q == ST_MODIFY);
	assign out_valid = out_valid_q;
	assign cur       = vld_q[idx_q] ? entry_t'(rdata) : ENTRY_RESET;

	kst_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(POSITIONS)
	) u_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (idx_q),
		.wdata (nxt),
		.re    (in_fire),
		.raddr (in_idx),
		.rdata (rdata)
	);

	kst_update u_update (
		.cur          (cur),
		.pressed      (pressed_q),
		.timestamp_ms (ts_q),
		.source       (src_q),
		.nxt          (nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			vld_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (out_valid_q && out_ready) begin
						out_valid_q <= 1'b0;
					end
					if (in_fire) begin
						idx_q      <= in_idx;
						in_range_q <= in_range;
						pressed_q  <= pressed;
						ts_q       <= timestamp_ms;
						src_q      <= source;
						unique case (op)
							OP_EVENT: begin
								if (in_range) begin
									state_q <= ST_MODIFY;
								end
							end
							OP_READ:  state_q <= ST_READ;
							OP_CLEAR: vld_q <= '0;
							default:  state_q <= ST_IDLE;
						endcase
					end
				end
				ST_MODIFY: begin
					if (out_valid_q && out_ready) begin
						out_valid_q <= 1'b0;
					end
					vld_q[idx_q] <= 1'b1;
					state_q      <= ST_IDLE;
				end
				ST_READ: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
						if (in_range_q) begin
							valid_res      <= 1'b1;
							press_total    <= cur.press_cnt;
							release_total  <= cur.release_cnt;
							last_source_id <= cur.last_src;
							min_hold_ms    <= cur.min_hold;
							min_gap_ms     <= cur.min_gap;
							gaps_under_5   <= cur.bucket[0];
							gaps_under_10  <= cur.bucket[1];
							gaps_under_20  <= cur.bucket[2];
							gaps_under_50  <= cur.bucket[3];
						end else begin
							valid_res      <= 1'b0;
							press_total    <= '0;
							release_total  <= '0;
							last_source_id <= '0;
							min_hold_ms    <= '0;
							min_gap_ms     <= '0;
							gaps_under_5   <= '0;
							gaps_under_10  <= '0;
							gaps_under_20  <= '0;
							gaps_under_50  <= '0;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_modify_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MODIFY) |-> !in_ready)
		else $error("input taken during write-back");

	a_clear_drops_flags: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && (op == OP_CLEAR)) |=> (vld_q == '0))
		else $error("clear left valid flags set");

	a_event_writes_back: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && (op == OP_EVENT) && in_range) |=> wr_en)
		else $error("in-range event not written back");

	a_invalid_read_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !valid_res) |-> ((press_total == '0) && (release_total == '0)
			&& (min_hold_ms == '0) && (min_gap_ms == '0) && (last_source_id == '0)))
		else $error("out-of-range read returned nonzero fields");

	a_read_reaches_output: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && (op == OP_READ)) |=> (state_q == ST_READ))
		else $error("read did not enter read state");

endmodule

/* test/tb_key_event_stats_table_top.sv */
// Testbench for the key event statistics table: directed, back-pressure and random beats.
module tb_key_event_stats_table_top import kst_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 3_000_000;
	localparam int LONG_HOLD = 300;
	localparam int RANDOM_BEATS = 460;

	typedef struct packed {
		logic [1:0]  op;
		logic [7:0]  pos;
		logic        pressed;
		logic [31:0] ts;
		logic [7:0]  src;
	} key_beat_t;

	typedef struct packed {
		logic [15:0]      presses;
		logic [15:0]      releases;
		logic [7:0]       src;
		logic [15:0]      min_hold;
		logic [15:0]      min_gap;
		logic [3:0][15:0] bucket;
		logic [31:0]      t_press;
		logic [31:0]      t_release;
		logic             seen_press;
		logic             seen_release;
	} key_stats_t;

	typedef struct packed {
		logic             valid;
		logic [15:0]      presses;
		logic [15:0]      releases;
		logic [7:0]       src;
		logic [15:0]      min_hold;
		logic [15:0]      min_gap;
		logic [3:0][15:0] bucket;
	} read_result_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  op;
	logic [7:0]  position;
	logic        pressed;
	logic [31:0] timestamp_ms;
	logic [7:0]  source;
	logic        out_valid;
	logic        out_ready;
	logic        valid_res;
	logic [15:0] press_total;
	logic [15:0] release_total;
	logic [7:0]  last_source_id;
	logic [15:0] min_hold_ms;
	logic [15:0] min_gap_ms;
	logic [15:0] gaps_under_5;
	logic [15:0] gaps_under_10;
	logic [15:0] gaps_under_20;
	logic [15:0] gaps_under_50;

	key_stats_t   key_table [POSITIONS];
	read_result_t pending_reads [$];
	int           mismatches = 0;
	int           cycle_count = 0;
	bit           sender_quiet = 1'b0;
	bit           receiver_quiet = 1'b0;
	bit           hold_off_req = 1'b0;

	key_event_stats_table_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.op            (op),
		.position      (position),
		.pressed       (pressed),
		.timestamp_ms  (timestamp_ms),
		.source        (source),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.valid_res     (valid_res),
		.press_total   (press_total),
		.release_total (release_total),
		.last_source_id(last_source_id),
		.min_hold_ms   (min_hold_ms),
		.min_gap_ms    (min_gap_ms),
		.gaps_under_5  (gaps_under_5),
		.gaps_under_10 (gaps_under_10),
		.gaps_under_20 (gaps_under_20),
		.gaps_under_50 (gaps_under_50)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	function automatic int idle_len(bit quiet);
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 80);
	endfunction

	function automatic logic [15:0] bump16(logic [15:0] v);
		return (v == 16'hFFFF) ? v : v + 16'd1;
	endfunction

	function automatic key_beat_t beat_of(logic [1:0] o, logic [7:0] p, logic pr,
			logic [31:0] t, logic [7:0] s);
		key_beat_t b;
		b.op = o;
		b.pos = p;
		b.pressed = pr;
		b.ts = t;
		b.src = s;
		return b;
	endfunction

	task automatic clear_key_table();
		key_stats_t e;
		e = '0;
		e.min_hold = 16'hFFFF;
		e.min_gap = 16'hFFFF;
		for (int i = 0; i < POSITIONS; i++)
			key_table[i] = e;
	endtask

	task automatic update_key_stats(input key_beat_t b);
		int p;
		logic [31:0] dt;
		key_stats_t e;
		read_result_t r;
		p = int'(b.pos);
		case (b.op)
			OP_EVENT: begin
				if (p < POSITIONS) begin
					e = key_table[p];
					e.src = b.src;
					if (b.pressed) begin
						e.presses = bump16(e.presses);
						if (e.seen_release) begin
							dt = b.ts - e.t_release;
							if (dt < {16'd0, e.min_gap})
								e.min_gap = dt[15:0];
							if (dt < 32'd5)
								e.bucket[0] = bump16(e.bucket[0]);
							else if (dt < 32'd10)
								e.bucket[1] = bump16(e.bucket[1]);
							else if (dt < 32'd20)
								e.bucket[2] = bump16(e.bucket[2]);
							else if (dt < 32'd50)
								e.bucket[3] = bump16(e.bucket[3]);
						end
						e.t_press = b.ts;
						e.seen_press = 1'b1;
					end else begin
						e.releases = bump16(e.releases);
						if (e.seen_press) begin
							dt = b.ts - e.t_press;
							if (dt < {16'd0, e.min_hold})
								e.min_hold = dt[15:0];
						end
						e.t_release = b.ts;
						e.seen_release = 1'b1;
					end
					key_table[p] = e;
				end
			end
			OP_READ: begin
				r = '0;
				if (p < POSITIONS) begin
					e = key_table[p];
					r.valid = 1'b1;
					r.presses = e.presses;
					r.releases = e.releases;
					r.src = e.src;
					r.min_hold = e.min_hold;
					r.min_gap = e.min_gap;
					r.bucket = e.bucket;
				end
				pending_reads.push_back(r);
			end
			OP_CLEAR: clear_key_table();
			default: ;
		endcase
	endtask

	task automatic send_beat(input key_beat_t b);
		int gap;
		gap = idle_len(sender_quiet);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		op <= b.op;
		position <= b.pos;
		pressed <= b.pressed;
		timestamp_ms <= b.ts;
		source <= b.src;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		update_key_stats(b);
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		read_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_reads.size() == 0) begin
				$error("result beat with no read pending");
				mismatches++;
			end else begin
				want = pending_reads.pop_front();
				check_field("valid_res", 32'(want.valid), 32'(valid_res));
				check_field("press_total", 32'(want.presses), 32'(press_total));
				check_field("release_total", 32'(want.releases), 32'(release_total));
				check_field("last_source_id", 32'(want.src), 32'(last_source_id));
				check_field("min_hold_ms", 32'(want.min_hold), 32'(min_hold_ms));
				check_field("min_gap_ms", 32'(want.min_gap), 32'(min_gap_ms));
				check_field("gaps_under_5", 32'(want.bucket[0]), 32'(gaps_under_5));
				check_field("gaps_under_10", 32'(want.bucket[1]), 32'(gaps_under_10));
				check_field("gaps_under_20", 32'(want.bucket[2]), 32'(gaps_under_20));
				check_field("gaps_under_50", 32'(want.bucket[3]), 32'(gaps_under_50));
			end
		end
	end

	initial begin
		int stall;
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else begin
				stall = idle_len(receiver_quiet);
				if (stall > 0) begin
					out_ready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
				out_ready <= 1'b1;
			end
		end
	end

	task automatic test_directed();
		send_beat(beat_of(OP_READ, 8'd0, 1'b0, 32'd0, 8'd0));
		send_beat(beat_of(OP_READ, 8'd63, 1'b1, 32'hFFFF_FFFF, 8'hFF));
		send_beat(beat_of(OP_READ, 8'd64, 1'b0, 32'd0, 8'd0));
		send_beat(beat_of(OP_READ, 8'd255, 1'b0, 32'd0, 8'd0));
		send_beat(beat_of(OP_EVENT, 8'd0, 1'b0, 32'd1000, 8'h00));
		send_beat(beat_of(OP_EVENT, 8'd0, 1'b1, 32'd1004, 8'hFF));
		send_beat(beat_of(OP_EVENT, 8'd0, 1'b0, 32'd1009, 8'h01));
		send_beat(beat_of(OP_EVENT, 8'd0, 1'b1, 32'd1014, 8'h02));
		send_beat(beat_of(OP_EVENT, 8'd0, 1'b0, 32'd1015, 8'h04));
		send_beat(beat_of(OP_EVENT, 8'd0, 1'b1, 32'd1034, 8'h08));
		send_beat(beat_of(OP_EVENT, 8'd0, 1'b0, 32'd1040, 8'h10));
		send_beat(beat_of(OP_EVENT, 8'd0, 1'b1, 32'd1089, 8'h20));
		send_beat(beat_of(OP_EVENT, 8'd0, 1'b0, 32'd1100, 8'h40));
		send_beat(beat_of(OP_EVENT, 8'd0, 1'b1, 32'd1150, 8'h80));
		send_beat(beat_of(OP_READ, 8'd0, 1'b0, 32'd0, 8'd0));
		send_beat(beat_of(OP_EVENT, 8'd63, 1'b1, 32'hFFFF_FFFE, 8'h5A));
		send_beat(beat_of(OP_EVENT, 8'd63, 1'b0, 32'h0000_0003, 8'hA5));
		send_beat(beat_of(OP_EVENT, 8'd1, 1'b1, 32'd0, 8'h33));
		send_beat(beat_of(OP_EVENT, 8'd1, 1'b0, 32'h0001_0000, 8'hCC));
		send_beat(beat_of(OP_EVENT, 8'd64, 1'b1, 32'd1151, 8'h11));
		send_beat(beat_of(OP_EVENT, 8'd255, 1'b0, 32'd1152, 8'h22));
		send_beat(beat_of(OP_UNUSED, 8'd0, 1'b1, 32'd1153, 8'h44));
		send_beat(beat_of(OP_READ, 8'd0, 1'b0, 32'd0, 8'd0));
		send_beat(beat_of(OP_READ, 8'd63, 1'b0, 32'd0, 8'd0));
		send_beat(beat_of(OP_READ, 8'd1, 1'b0, 32'd0, 8'd0));
		send_beat(beat_of(OP_CLEAR, 8'd0, 1'b0, 32'd0, 8'd0));
		send_beat(beat_of(OP_READ, 8'd0, 1'b0, 32'd0, 8'd0));
		send_beat(beat_of(OP_READ, 8'd63, 1'b0, 32'd0, 8'd0));
	endtask

	task automatic test_output_stall();
		sender_quiet = 1'b1;
		hold_off_req = 1'b1;
		for (int i = 0; i < 16; i++)
			send_beat(beat_of(OP_READ, 8'($urandom_range(0, POSITIONS - 1)), 1'b0,
				32'd0, 8'd0));
		sender_quiet = 1'b0;
	endtask

	task automatic test_random();
		int sent;
		int r;
		int p;
		logic [31:0] now_ms;
		logic [31:0] dt;
		bit key_down [POSITIONS];
		key_beat_t b;
		sent = 0;
		now_ms = $urandom();
		foreach (key_down[i])
			key_down[i] = 1'b0;
		while (sent < RANDOM_BEATS) begin
			if (sent % 20 == 0) begin
				sender_quiet = ($urandom_range(0, 5) == 0);
				receiver_quiet = ($urandom_range(0, 5) == 0);
			end
			r = $urandom_range(0, 99);
			p = $urandom_range(0, 99);
			p = (p < 60) ? $urandom_range(0, 7) : (p < 75) ? POSITIONS - 1 :
				$urandom_range(0, POSITIONS - 1);
			b = beat_of(OP_EVENT, 8'(p), 1'b0, now_ms, 8'($urandom_range(0, 255)));
			if (r < 25) begin
				b.op = OP_READ;
				if ($urandom_range(0, 9) == 0)
					b.pos = 8'($urandom_range(0, 255));
				b.pressed = 1'($urandom_range(0, 1));
				b.ts = $urandom();
			end else if (r < 27) begin
				b.pos = 8'($urandom_range(POSITIONS, 255));
				b.pressed = 1'($urandom_range(0, 1));
				b.ts = $urandom();
			end else if (r < 29) begin
				b.op = OP_UNUSED;
				b.pos = 8'($urandom_range(0, 255));
				b.pressed = 1'($urandom_range(0, 1));
				b.ts = $urandom();
			end else if (r < 30) begin
				b.op = OP_CLEAR;
				b.pos = 8'($urandom_range(0, 255));
			end else if (r < 35) begin
				b.pressed = 1'($urandom_range(0, 1));
				b.ts = $urandom();
			end else begin
				r = $urandom_range(0, 99);
				dt = (r < 50) ? 32'($urandom_range(0, 60)) :
					(r < 80) ? 32'($urandom_range(60, 400)) :
					(r < 95) ? 32'($urandom_range(0, 4)) : $urandom();
				now_ms = now_ms + dt;
				key_down[p] = !key_down[p];
				b.pressed = key_down[p];
				b.ts = now_ms;
			end
			send_beat(b);
			sent++;
		end
		sender_quiet = 1'b0;
		receiver_quiet = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		op = OP_EVENT;
		position = 8'd0;
		pressed = 1'b0;
		timestamp_ms = 32'd0;
		source = 8'd0;
		clear_key_table();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_output_stall();
		test_random();
		in_valid <= 1'b0;
		while (pending_reads.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0 && pending_reads.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
